### hw/rtl/dpbm_pkg.sv
// ----------------------------------------------------------------------------
// Decoded picture buffer manager package
// Shared constants, operation codes and the slot store command type.
// ----------------------------------------------------------------------------
package dpbm_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 34;

  localparam logic [3:0] FUNC_CLEAR   = 4'd0;
  localparam logic [3:0] FUNC_OCCUPY  = 4'd1;
  localparam logic [3:0] FUNC_MARKREF = 4'd2;
  localparam logic [3:0] FUNC_RELEASE = 4'd3;
  localparam logic [3:0] FUNC_LIST0   = 4'd4;
  localparam logic [3:0] FUNC_LIST1   = 4'd5;
  localparam logic [3:0] FUNC_PLIST   = 4'd6;
  localparam logic [3:0] FUNC_WINDOW  = 4'd7;
  localparam logic [3:0] FUNC_MMCO    = 4'd8;

  localparam logic [2:0] MMCO_SHORT   = 3'd1;
  localparam logic [2:0] MMCO_LONG    = 3'd2;
  localparam logic [2:0] MMCO_ALL     = 3'd5;
  localparam logic [2:0] MMCO_CUR     = 3'd6;

  localparam logic [1:0] CFG_LOG2_MAX_FN = 2'd0;
  localparam logic [1:0] CFG_CODEC_H264  = 2'd1;
  localparam logic [1:0] CFG_MAX_REF     = 2'd2;

  localparam int FL_USE = 0;
  localparam int FL_REF = 1;
  localparam int FL_LT  = 2;

  typedef struct packed {
    logic              clr_all;
    logic              clr_ref_all;
    logic              wr_occ;
    logic              wr_ref;
    logic              drop;
    logic              set_ref;
    logic [SLOT_W-1:0] addr;
  } store_cmd_t;

endpackage

### hw/rtl/dpbm_if.sv
// ----------------------------------------------------------------------------
// Decoded picture buffer manager channels
// Input, result and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface dpbm_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic [3:0]         slot;
  logic signed [31:0] poc;
  logic signed [31:0] current_poc;
  logic [15:0]        frame_num;
  logic [31:0]        decode_order;
  logic               long_term;
  logic [15:0]        current_frame_num;
  logic [2:0]         mmco_op;
  logic [15:0]        mmco_value;
  modport source(output valid, func, slot, poc, current_poc, frame_num, decode_order,
                 long_term, current_frame_num, mmco_op, mmco_value, input ready);
  modport sink(input valid, func, slot, poc, current_poc, frame_num, decode_order,
               long_term, current_frame_num, mmco_op, mmco_value, output ready);
endinterface

interface dpbm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] slot_index;
  logic       entry_valid;
  logic       last;
  modport source(output valid, slot_index, entry_valid, last, input ready);
  modport sink(input valid, slot_index, entry_valid, last, output ready);
endinterface

interface dpbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/dpbm_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Holds the marks, order count, frame number and decode order of every slot.
// ----------------------------------------------------------------------------
module dpbm_slot_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpbm_pkg::store_cmd_t         cmd_i,
  input  logic signed [31:0]           poc_i,
  input  logic [15:0]                  frame_num_i,
  input  logic [31:0]                  decode_order_i,
  input  logic                         long_term_i,
  input  logic [dpbm_pkg::SLOT_W-1:0]  rd_addr_i,
  output logic [2:0]                   rd_flags_o,
  output logic signed [31:0]           rd_poc_o,
  output logic [15:0]                  rd_frame_num_o,
  output logic [31:0]                  rd_decode_order_o
);

  logic [2:0]         flags_q [dpbm_pkg::SLOTS];
  logic signed [31:0] poc_q   [dpbm_pkg::SLOTS];
  logic [15:0]        fn_q    [dpbm_pkg::SLOTS];
  logic [31:0]        dord_q  [dpbm_pkg::SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < dpbm_pkg::SLOTS; s++) begin
        flags_q[s] <= '0;
        poc_q[s]   <= '1;
        fn_q[s]    <= '0;
        dord_q[s]  <= '0;
      end
    end else if (cmd_i.clr_all) begin
      for (int s = 0; s < dpbm_pkg::SLOTS; s++) begin
        flags_q[s] <= '0;
        poc_q[s]   <= '1;
        fn_q[s]    <= '0;
        dord_q[s]  <= '0;
      end
    end else if (cmd_i.clr_ref_all) begin
      for (int s = 0; s < dpbm_pkg::SLOTS; s++) begin
        flags_q[s][dpbm_pkg::FL_REF] <= 1'b0;
      end
    end else if (cmd_i.wr_occ) begin
      flags_q[cmd_i.addr] <= {long_term_i, 1'b0, 1'b1};
      fn_q[cmd_i.addr]    <= frame_num_i;
      dord_q[cmd_i.addr]  <= decode_order_i;
    end else if (cmd_i.wr_ref) begin
      flags_q[cmd_i.addr][dpbm_pkg::FL_REF] <= 1'b1;
      poc_q[cmd_i.addr] <= poc_i;
    end else if (cmd_i.set_ref) begin
      flags_q[cmd_i.addr][dpbm_pkg::FL_REF] <= 1'b1;
    end else if (cmd_i.drop) begin
      flags_q[cmd_i.addr][dpbm_pkg::FL_REF] <= 1'b0;
      flags_q[cmd_i.addr][dpbm_pkg::FL_USE] <= 1'b0;
    end
  end

  assign rd_flags_o        = flags_q[rd_addr_i];
  assign rd_poc_o          = poc_q[rd_addr_i];
  assign rd_frame_num_o    = fn_q[rd_addr_i];
  assign rd_decode_order_o = dord_q[rd_addr_i];

endmodule

### hw/rtl/decoded_picture_buffer_manager_unit.sv
// ----------------------------------------------------------------------------
// Decoded picture buffer manager
// Sequencer that scans the slot store, sorts lists and applies marking rules.
// ----------------------------------------------------------------------------
// Clear, occupy, mark and release operations write the slot store when the
// transaction is accepted; list builds scan every slot, sort the candidates
// with an exchange sort, then give one result per cycle while the output is
// not stalled; the sliding window rescans the slots for each eviction. One item
// at a time: the single candidate read port is shared by the sort and result steps. Reset clears all slot marks.
module decoded_picture_buffer_manager_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpbm_in_if.sink     in_i,
  dpbm_out_if.source  out_o,
  dpbm_cfg_if.sink    cfg_i
);

  localparam int SW = dpbm_pkg::SLOT_W;
  localparam int CW = dpbm_pkg::CNT_W;
  localparam int KW = dpbm_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SORT_LD, S_SORT_CMP, S_EMIT,
    S_WCOUNT, S_WCHK, S_WFIND, S_WDROP, S_MMCO
  } state_e;

  state_e state_q;
  logic [4:0] log2_q, maxref_q;
  logic       h264_q;

  logic [3:0]         func_q;
  logic [2:0]         op_q;
  logic [15:0]        val_q, cfn_q;
  logic signed [31:0] cpoc_q;
  logic [CW-1:0]      i_q, j_q, n_q, lo_q, k_q, cnt_q;
  logic               phase_q, best_v_q;
  logic [SW-1:0]      best_q, held_idx_q;
  logic signed [KW-1:0] best_key_q, held_key_q;
  logic [SW-1:0]        cand_idx_q [dpbm_pkg::SLOTS];
  logic signed [KW-1:0] cand_key_q [dpbm_pkg::SLOTS];
  logic       ov_q, oev_q, olast_q;
  logic [3:0] oidx_q;

  dpbm_pkg::store_cmd_t cmd;
  logic [2:0]         rd_flags;
  logic signed [31:0] rd_poc;
  logic [15:0]        rd_fn;
  logic [31:0]        rd_dord;

  logic in_fire, out_fire, slot_ok, active, is_lt, last_scan, desc, sw;
  logic cand_ok, cand_we, fn_gt, hit;
  logic signed [KW-1:0] pic_num, scan_key, cand_wkey, rd_key, target, win_key;
  logic [SW-1:0] cand_wpos, cand_widx, rpos;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid       = ov_q;
  assign out_o.slot_index  = oidx_q;
  assign out_o.entry_valid = oev_q;
  assign out_o.last        = olast_q;

  assign slot_ok = (32'(in_i.slot) < dpbm_pkg::SLOTS);

  dpbm_slot_store u_store (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .poc_i(in_i.poc), .frame_num_i(in_i.frame_num),
    .decode_order_i(in_i.decode_order), .long_term_i(in_i.long_term),
    .rd_addr_i(i_q[SW-1:0]), .rd_flags_o(rd_flags), .rd_poc_o(rd_poc),
    .rd_frame_num_o(rd_fn), .rd_decode_order_o(rd_dord)
  );

  always_comb begin
    active    = rd_flags[dpbm_pkg::FL_USE] && rd_flags[dpbm_pkg::FL_REF];
    is_lt     = rd_flags[dpbm_pkg::FL_LT];
    last_scan = (i_q == CW'(dpbm_pkg::SLOTS - 1));
    fn_gt     = (rd_fn > cfn_q);
    pic_num   = $signed(KW'(rd_fn)) - (fn_gt ? $signed(KW'(1) << log2_q) : $signed(KW'(0)));
    target    = $signed(KW'(cfn_q)) - $signed(KW'(val_q)) - $signed(KW'(1));
    hit       = (op_q == dpbm_pkg::MMCO_SHORT) ? (pic_num == target) : (rd_fn == val_q);
    win_key   = (!h264_q || log2_q == 5'd0) ? $signed(KW'(rd_dord)) : pic_num;
    desc      = (func_q == dpbm_pkg::FUNC_LIST0) ||
                (func_q == dpbm_pkg::FUNC_PLIST && !phase_q);
    cand_ok   = 1'b0;
    scan_key  = $signed({{(KW-32){rd_poc[31]}}, rd_poc});
    case (func_q)
      dpbm_pkg::FUNC_LIST0: cand_ok = active && (rd_poc < cpoc_q);
      dpbm_pkg::FUNC_LIST1: cand_ok = active && (rd_poc > cpoc_q);
      dpbm_pkg::FUNC_PLIST: begin
        cand_ok  = active && (is_lt == phase_q);
        scan_key = phase_q ? $signed(KW'(rd_fn)) : pic_num;
      end
      default: cand_ok = 1'b0;
    endcase
    case (state_q)
      S_SORT_LD: rpos = i_q[SW-1:0];
      S_EMIT:    rpos = k_q[SW-1:0];
      default:   rpos = j_q[SW-1:0];
    endcase
    rd_key = cand_key_q[rpos];
    sw = desc ? (rd_key > held_key_q) : (rd_key < held_key_q);
    cand_we = 1'b0;
    cand_wpos = n_q[SW-1:0];
    cand_widx = i_q[SW-1:0];
    cand_wkey = scan_key;
    if (state_q == S_SCAN) begin
      cand_we = cand_ok;
    end else if (state_q == S_SORT_CMP) begin
      cand_widx = held_idx_q;
      cand_wkey = held_key_q;
      if (j_q < n_q) begin
        cand_we   = sw;
        cand_wpos = j_q[SW-1:0];
      end else begin
        cand_we   = 1'b1;
        cand_wpos = i_q[SW-1:0];
      end
    end
    cmd = '0;
    cmd.addr = SW'(in_i.slot);
    if (in_fire) begin
      case (in_i.func)
        dpbm_pkg::FUNC_CLEAR:   cmd.clr_all = 1'b1;
        dpbm_pkg::FUNC_OCCUPY:  cmd.wr_occ = slot_ok;
        dpbm_pkg::FUNC_MARKREF: cmd.wr_ref = slot_ok;
        dpbm_pkg::FUNC_RELEASE: cmd.drop = slot_ok;
        dpbm_pkg::FUNC_MMCO: begin
          cmd.clr_ref_all = (in_i.mmco_op == dpbm_pkg::MMCO_ALL);
          cmd.set_ref     = (in_i.mmco_op == dpbm_pkg::MMCO_CUR) && slot_ok;
        end
        default: cmd = cmd;
      endcase
    end else if (state_q == S_MMCO) begin
      cmd.addr = i_q[SW-1:0];
      cmd.drop = active && !is_lt && hit;
    end else if (state_q == S_WDROP) begin
      cmd.addr = best_q;
      cmd.drop = best_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_idx_q[cand_wpos] <= cand_widx;
      cand_key_q[cand_wpos] <= cand_wkey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q   <= '0;
      h264_q   <= 1'b1;
      maxref_q <= 5'd16;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dpbm_pkg::CFG_LOG2_MAX_FN: log2_q   <= cfg_i.data;
        dpbm_pkg::CFG_CODEC_H264:  h264_q   <= cfg_i.data[0];
        dpbm_pkg::CFG_MAX_REF:     maxref_q <= cfg_i.data;
        default:                   log2_q   <= log2_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0; oev_q <= 1'b0; olast_q <= 1'b0; oidx_q <= '0;
      func_q <= '0; op_q <= '0; val_q <= '0; cfn_q <= '0; cpoc_q <= '0;
      i_q <= '0; j_q <= '0; n_q <= '0; lo_q <= '0; k_q <= '0; cnt_q <= '0;
      phase_q <= 1'b0; best_v_q <= 1'b0; best_q <= '0; best_key_q <= '0;
      held_idx_q <= '0; held_key_q <= '0;
    end else begin
      if (out_fire) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            func_q <= in_i.func; op_q <= in_i.mmco_op; val_q <= in_i.mmco_value;
            cfn_q <= in_i.current_frame_num; cpoc_q <= in_i.current_poc;
            i_q <= '0; n_q <= '0; lo_q <= '0; phase_q <= 1'b0; cnt_q <= '0;
            case (in_i.func)
              dpbm_pkg::FUNC_LIST0, dpbm_pkg::FUNC_LIST1,
              dpbm_pkg::FUNC_PLIST:  state_q <= S_SCAN;
              dpbm_pkg::FUNC_WINDOW: state_q <= S_WCOUNT;
              dpbm_pkg::FUNC_MMCO: begin
                if (in_i.mmco_op == dpbm_pkg::MMCO_SHORT ||
                    in_i.mmco_op == dpbm_pkg::MMCO_LONG) state_q <= S_MMCO;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (cand_ok) n_q <= n_q + CW'(1);
          i_q <= i_q + CW'(1);
          if (last_scan) begin
            i_q <= lo_q;
            state_q <= S_SORT_LD;
          end
        end
        S_SORT_LD: begin
          if (i_q < n_q) begin
            held_idx_q <= cand_idx_q[rpos];
            held_key_q <= rd_key;
            j_q <= i_q + CW'(1);
            state_q <= S_SORT_CMP;
          end else if (func_q == dpbm_pkg::FUNC_PLIST && !phase_q) begin
            phase_q <= 1'b1;
            lo_q <= n_q;
            i_q <= '0;
            state_q <= S_SCAN;
          end else begin
            k_q <= '0;
            state_q <= S_EMIT;
          end
        end
        S_SORT_CMP: begin
          if (j_q < n_q) begin
            if (sw) begin
              held_idx_q <= cand_idx_q[rpos];
              held_key_q <= rd_key;
            end
            j_q <= j_q + CW'(1);
          end else begin
            i_q <= i_q + CW'(1);
            state_q <= S_SORT_LD;
          end
        end
        S_EMIT: begin
          if (!ov_q || out_o.ready) begin
            ov_q    <= 1'b1;
            oev_q   <= (n_q != '0);
            oidx_q  <= (n_q == '0) ? 4'd0 : 4'(cand_idx_q[rpos]);
            olast_q <= (n_q == '0) || (k_q == n_q - CW'(1));
            k_q     <= k_q + CW'(1);
            if ((n_q == '0) || (k_q == n_q - CW'(1))) state_q <= S_IDLE;
          end
        end
        S_WCOUNT: begin
          if (active) cnt_q <= cnt_q + CW'(1);
          i_q <= i_q + CW'(1);
          if (last_scan) state_q <= S_WCHK;
        end
        S_WCHK: begin
          i_q <= '0;
          best_v_q <= 1'b0;
          state_q <= (32'(cnt_q) >= 32'(maxref_q)) ? S_WFIND : S_IDLE;
        end
        S_WFIND: begin
          if (active && !is_lt && (!best_v_q || win_key < best_key_q)) begin
            best_v_q <= 1'b1;
            best_q <= i_q[SW-1:0];
            best_key_q <= win_key;
          end
          i_q <= i_q + CW'(1);
          if (last_scan) state_q <= S_WDROP;
        end
        S_WDROP: begin
          if (best_v_q) begin
            cnt_q <= cnt_q - CW'(1);
            state_q <= S_WCHK;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MMCO: begin
          i_q <= i_q + CW'(1);
          if (cmd.drop || last_scan) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.entry_valid) |-> out_o.last)
    else $error("Empty list result without last mark.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(dpbm_pkg::SLOTS))
    else $error("Candidate count exceeds slot count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.func == dpbm_pkg::FUNC_LIST0 || in_i.func == dpbm_pkg::FUNC_LIST1 ||
     in_i.func == dpbm_pkg::FUNC_PLIST)) |=> !in_i.ready)
    else $error("List transaction did not start a scan.");

endmodule

### verif/dpbm_tb_if.sv
// ----------------------------------------------------------------------------
// Decoded picture buffer manager testbench channel helpers
// Holds the transaction record types shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package dpbm_tb_pkg;

  typedef struct {
    logic [3:0]         func;
    logic [3:0]         slot;
    logic signed [31:0] poc;
    logic signed [31:0] current_poc;
    logic [15:0]        frame_num;
    logic [31:0]        decode_order;
    logic               long_term;
    logic [15:0]        current_frame_num;
    logic [2:0]         mmco_op;
    logic [15:0]        mmco_value;
  } pic_op_t;

  typedef struct {
    logic [3:0] slot_index;
    logic       entry_valid;
    logic       last;
  } list_entry_t;

endpackage

### verif/decoded_picture_buffer_manager_unit_tb.sv
// ----------------------------------------------------------------------------
// Decoded picture buffer manager testbench
// Drives register writes, and slot operations under random idling, predicts
// every list transaction and compares each result field by field.
// ----------------------------------------------------------------------------
module decoded_picture_buffer_manager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpbm_pkg::*;
  import dpbm_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  dpbm_in_if  in_ch();
  dpbm_out_if out_ch();
  dpbm_cfg_if cfg_ch();

  decoded_picture_buffer_manager_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // Predicted slot store and registers.
  logic [2:0]         pic_flags[SLOTS];
  logic signed [31:0] pic_poc[SLOTS];
  logic [15:0]        pic_fnum[SLOTS];
  logic [31:0]        pic_dord[SLOTS];
  logic [4:0]         reg_log2_fn;
  logic               reg_h264;
  logic [4:0]         reg_max_ref;

  list_entry_t expected_entries[$];
  int errors = 0;
  int list_count = 0;
  int entry_count = 0;
  int cycles = 0;
  logic hold_results = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit is_ref(int i);
    return pic_flags[i][FL_USE] && pic_flags[i][FL_REF];
  endfunction

  function automatic longint pic_number(int i, longint curr);
    longint fn;
    fn = longint'(pic_fnum[i]);
    return (fn > curr) ? fn - (longint'(1) << reg_log2_fn) : fn;
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < SLOTS; i++) begin
      pic_flags[i] = '0;
      pic_poc[i] = -1;
      pic_fnum[i] = '0;
      pic_dord[i] = '0;
    end
  endfunction

  function automatic void drop_pic(int i);
    pic_flags[i][FL_USE] = 1'b0;
    pic_flags[i][FL_REF] = 1'b0;
  endfunction

  function automatic void exchange_sort(ref int idx[SLOTS], ref longint key[SLOTS],
                                        input int lo, input int hi, input bit desc);
    int ti;
    longint tk;
    for (int i = lo; i < hi; i++)
      for (int j = i + 1; j < hi; j++)
        if (desc ? (key[j] > key[i]) : (key[j] < key[i])) begin
          ti = idx[i]; tk = key[i];
          idx[i] = idx[j]; key[i] = key[j];
          idx[j] = ti; key[j] = tk;
        end
  endfunction

  // Applies one operation to the predicted store; queues any list it produces.
  function automatic void predict_op(pic_op_t op);
    int idx[SLOTS];
    longint key[SLOTS];
    int n, m, best, cnt;
    longint curr, bkey, k, target;
    bit by_order, hit;
    list_entry_t e;
    n = 0;
    curr = longint'(op.current_frame_num);
    case (op.func)
      FUNC_CLEAR: wipe_store();
      FUNC_OCCUPY: begin
        pic_flags[op.slot] = {op.long_term, 1'b0, 1'b1};
        pic_fnum[op.slot] = op.frame_num;
        pic_dord[op.slot] = op.decode_order;
      end
      FUNC_MARKREF: begin
        pic_flags[op.slot][FL_REF] = 1'b1;
        pic_poc[op.slot] = op.poc;
      end
      FUNC_RELEASE: drop_pic(op.slot);
      FUNC_WINDOW: begin
        by_order = !reg_h264 || (reg_log2_fn == 0);
        cnt = 0;
        for (int i = 0; i < SLOTS; i++) if (is_ref(i)) cnt++;
        while (cnt >= reg_max_ref) begin
          best = -1;
          bkey = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!is_ref(i) || pic_flags[i][FL_LT]) continue;
            k = by_order ? longint'(pic_dord[i]) : pic_number(i, curr);
            if (best < 0 || k < bkey) begin
              best = i;
              bkey = k;
            end
          end
          if (best < 0) break;
          drop_pic(best);
          cnt--;
        end
      end
      FUNC_MMCO: begin
        if (op.mmco_op == MMCO_SHORT || op.mmco_op == MMCO_LONG) begin
          target = curr - (longint'(op.mmco_value) + 1);
          for (int i = 0; i < SLOTS; i++) begin
            if (!is_ref(i) || pic_flags[i][FL_LT]) continue;
            hit = (op.mmco_op == MMCO_SHORT) ? (pic_number(i, curr) == target)
                                             : (pic_fnum[i] == op.mmco_value);
            if (hit) begin
              drop_pic(i);
              break;
            end
          end
        end else if (op.mmco_op == MMCO_ALL) begin
          for (int i = 0; i < SLOTS; i++) pic_flags[i][FL_REF] = 1'b0;
        end else if (op.mmco_op == MMCO_CUR) begin
          pic_flags[op.slot][FL_REF] = 1'b1;
        end
      end
      FUNC_LIST0, FUNC_LIST1: begin
        for (int i = 0; i < SLOTS; i++)
          if (is_ref(i) && ((op.func == FUNC_LIST0) ? (pic_poc[i] < op.current_poc)
                                                   : (pic_poc[i] > op.current_poc))) begin
            idx[n] = i;
            key[n] = longint'(pic_poc[i]);
            n++;
          end
        exchange_sort(idx, key, 0, n, op.func == FUNC_LIST0);
      end
      FUNC_PLIST: begin
        for (int i = 0; i < SLOTS; i++)
          if (is_ref(i) && !pic_flags[i][FL_LT]) begin
            idx[n] = i;
            key[n] = pic_number(i, curr);
            n++;
          end
        exchange_sort(idx, key, 0, n, 1'b1);
        m = n;
        for (int i = 0; i < SLOTS; i++)
          if (is_ref(i) && pic_flags[i][FL_LT]) begin
            idx[n] = i;
            key[n] = longint'(pic_fnum[i]);
            n++;
          end
        exchange_sort(idx, key, m, n, 1'b0);
      end
      default: ;
    endcase
    if (op.func inside {FUNC_LIST0, FUNC_LIST1, FUNC_PLIST}) begin
      list_count++;
      if (n == 0) begin
        e.slot_index = '0; e.entry_valid = 1'b0; e.last = 1'b1;
        expected_entries.push_back(e);
      end
      for (int i = 0; i < n; i++) begin
        e.slot_index = idx[i][3:0]; e.entry_valid = 1'b1; e.last = (i == n - 1);
        expected_entries.push_back(e);
      end
    end
  endfunction

  // Directed table: operation plus the typed expected last entry where obvious.
  typedef struct {
    pic_op_t     op;
    bit          has_fixed;
    list_entry_t fixed;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic pic_op_t mk(logic [3:0] f, logic [3:0] s, logic [31:0] poc,
                                 logic [31:0] cpoc, logic [15:0] fn, logic [31:0] dord,
                                 logic lt, logic [15:0] cfn, logic [2:0] mop,
                                 logic [15:0] mval);
    pic_op_t o;
    o.func = f; o.slot = s; o.poc = poc; o.current_poc = cpoc; o.frame_num = fn;
    o.decode_order = dord; o.long_term = lt; o.current_frame_num = cfn;
    o.mmco_op = mop; o.mmco_value = mval;
    return o;
  endfunction

  function automatic void add_row(pic_op_t o, bit fixed = 0, logic [3:0] si = 0,
                                  logic ev = 0);
    directed_row_t r;
    r.op = o; r.has_fixed = fixed;
    r.fixed.slot_index = si; r.fixed.entry_valid = ev; r.fixed.last = 1'b1;
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // Empty lists straight after reset.
    add_row(mk(FUNC_LIST0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(FUNC_LIST1, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(FUNC_PLIST, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0), 1, 0, 0);
    add_row(mk(FUNC_OCCUPY, 15, 0, 0, 16'hffff, 32'hffffffff, 1, 0, 0, 0));
    add_row(mk(FUNC_MARKREF, 15, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_LIST0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0), 1, 15, 1);
    add_row(mk(FUNC_OCCUPY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_MARKREF, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_OCCUPY, 3, 0, 0, 16'd5, 32'd7, 0, 0, 0, 0));
    add_row(mk(FUNC_MARKREF, 3, 32'd5, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_LIST1, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_PLIST, 0, 0, 0, 0, 0, 0, 16'd3, 0, 0));
    add_row(mk(FUNC_PLIST, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0));
    add_row(mk(FUNC_MMCO, 0, 0, 0, 0, 0, 0, 16'd5, 3'd0, 16'hffff));
    add_row(mk(FUNC_MMCO, 0, 0, 0, 0, 0, 0, 16'd6, MMCO_SHORT, 16'd0));
    add_row(mk(FUNC_MMCO, 0, 0, 0, 0, 0, 0, 0, MMCO_LONG, 16'd0));
    add_row(mk(FUNC_MMCO, 3, 0, 0, 0, 0, 0, 0, MMCO_CUR, 0));
    add_row(mk(4'd15, 7, 0, 0, 0, 0, 0, 0, 3'd7, 0));
    add_row(mk(FUNC_WINDOW, 0, 0, 0, 0, 0, 0, 16'd4, 0, 0));
    add_row(mk(FUNC_RELEASE, 15, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_MMCO, 0, 0, 0, 0, 0, 0, 0, MMCO_ALL, 0));
    add_row(mk(FUNC_LIST0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_PLIST, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
  endfunction

  task automatic send_op(pic_op_t op);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op.func; in_ch.slot <= op.slot; in_ch.poc <= op.poc;
    in_ch.current_poc <= op.current_poc; in_ch.frame_num <= op.frame_num;
    in_ch.decode_order <= op.decode_order; in_ch.long_term <= op.long_term;
    in_ch.current_frame_num <= op.current_frame_num; in_ch.mmco_op <= op.mmco_op;
    in_ch.mmco_value <= op.mmco_value;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_op(op);
  endtask

  task automatic write_reg(logic [1:0] index, logic [4:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (index)
      CFG_LOG2_MAX_FN: reg_log2_fn = value;
      CFG_CODEC_H264:  reg_h264 = value[0];
      CFG_MAX_REF:     reg_max_ref = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // Mostly a picture cycle: occupy, mark, list, window, with noise mixed in.
  function automatic pic_op_t random_op();
    pic_op_t o;
    int pick;
    o.slot = 4'($urandom_range(0, 15));
    o.poc = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 64)) - 32;
    o.current_poc = ($urandom_range(0, 5) == 0) ? $urandom()
                                                : $signed($urandom_range(0, 64)) - 32;
    o.frame_num = 16'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 20));
    o.decode_order = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 40);
    o.long_term = ($urandom_range(0, 4) == 0);
    o.current_frame_num = 16'(($urandom_range(0, 4) == 0) ? $urandom()
                                                          : $urandom_range(0, 20));
    o.mmco_op = 3'($urandom_range(0, 7));
    o.mmco_value = 16'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 22) o.func = FUNC_OCCUPY;
    else if (pick < 44) o.func = FUNC_MARKREF;
    else if (pick < 52) o.func = FUNC_RELEASE;
    else if (pick < 62) o.func = FUNC_LIST0;
    else if (pick < 71) o.func = FUNC_LIST1;
    else if (pick < 80) o.func = FUNC_PLIST;
    else if (pick < 87) o.func = FUNC_WINDOW;
    else if (pick < 95) o.func = FUNC_MMCO;
    else if (pick < 97) o.func = FUNC_CLEAR;
    else o.func = 4'($urandom_range(9, 15));
    return o;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    list_entry_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_results = 1'b0;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(0, 7)) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      entry_count++;
      if (expected_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected entry slot %0d", out_ch.slot_index));
      end else begin
        want = expected_entries.pop_front();
        if (out_ch.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, wanted %0d", out_ch.slot_index,
                                    want.slot_index));
        if (out_ch.entry_valid !== want.entry_valid)
          report_mismatch($sformatf("entry_valid %0b, wanted %0b", out_ch.entry_valid,
                                    want.entry_valid));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL decoded_picture_buffer_manager_unit");
      $finish;
    end
  end

  initial begin
    list_entry_t got;
    logic [4:0] settings[4][3];
    in_ch.valid = 1'b0;
    in_ch.func = '0; in_ch.slot = '0; in_ch.poc = '0; in_ch.current_poc = '0;
    in_ch.frame_num = '0; in_ch.decode_order = '0; in_ch.long_term = 1'b0;
    in_ch.current_frame_num = '0; in_ch.mmco_op = '0; in_ch.mmco_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    wipe_store();
    reg_log2_fn = 5'd0; reg_h264 = 1'b1; reg_max_ref = 5'd16;
    build_directed();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_op(directed_rows[r].op);
      if (directed_rows[r].has_fixed) begin
        got = expected_entries[expected_entries.size() - 1];
        if (got.slot_index !== directed_rows[r].fixed.slot_index ||
            got.entry_valid !== directed_rows[r].fixed.entry_valid)
          report_mismatch($sformatf("directed row %0d predicts slot %0d", r,
                                    got.slot_index));
        expected_entries[expected_entries.size() - 1] = directed_rows[r].fixed;
      end
    end
    drain();

    settings = '{'{5'd4, 5'd1, 5'd3}, '{5'd16, 5'd1, 5'd16},
                 '{5'd0, 5'd0, 5'd0}, '{5'd31, 5'd0, 5'd31}};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_LOG2_MAX_FN, settings[p][0]);
      write_reg(CFG_CODEC_H264, settings[p][1]);
      write_reg(CFG_MAX_REF, settings[p][2]);
      cfg_ch.valid <= 1'b0;
      for (int i = 0; i < 70; i++) begin
        if (p == 1 && i == 10) hold_results = 1'b1;
        send_op(random_op());
      end
      drain();
    end

    $display("covered %0d list builds and %0d list entries over four register settings",
             list_count, entry_count);
    if (errors == 0) begin
      $display("PASS decoded_picture_buffer_manager_unit");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL decoded_picture_buffer_manager_unit");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dpbm_pkg.sv
hw/rtl/dpbm_if.sv
hw/rtl/dpbm_slot_store.sv
hw/rtl/decoded_picture_buffer_manager_unit.sv
verif/dpbm_tb_if.sv
verif/decoded_picture_buffer_manager_unit_tb.sv
